/* hdl/kbd_pkg.sv */
// kbd_pkg: shared types, command codes, scancode constants and the set-1
// lookup tables for the scancode keyboard buffer.
// Depends on nothing; imported by the buffer top level.
package kbd_pkg;

  // ring geometry
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  typedef logic [RING_AW-1:0] ring_idx_t;
  typedef logic [CNT_W-1:0]   ring_cnt_t;

  // command codes
  localparam logic [1:0] CMD_SCAN  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // special scancodes
  localparam logic [7:0] SC_NONE   = 8'h00;
  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_LCTRL  = 8'h1D;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_LEFT   = 8'h4B;
  localparam logic [7:0] SC_RIGHT  = 8'h4D;
  localparam logic [7:0] SC_DOWN   = 8'h50;

  // character constants
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_EMPTY = 8'hFF;

  // advance a ring index with wrap
  function automatic ring_idx_t ring_bump(input ring_idx_t i);
    ring_bump = (i == ring_idx_t'(RING_DEPTH - 1)) ? '0 : ring_idx_t'(i + 1'b1);
  endfunction

  // unshifted table, codes past the end give zero
  function automatic logic [7:0] kbd_lower(input logic [6:0] idx);
    case (idx)
      7'd1:  kbd_lower = 8'h1B;
      7'd2:  kbd_lower = 8'h31;
      7'd3:  kbd_lower = 8'h32;
      7'd4:  kbd_lower = 8'h33;
      7'd5:  kbd_lower = 8'h34;
      7'd6:  kbd_lower = 8'h35;
      7'd7:  kbd_lower = 8'h36;
      7'd8:  kbd_lower = 8'h37;
      7'd9:  kbd_lower = 8'h38;
      7'd10: kbd_lower = 8'h39;
      7'd11: kbd_lower = 8'h30;
      7'd12: kbd_lower = 8'h2D;
      7'd13: kbd_lower = 8'h3D;
      7'd14: kbd_lower = 8'h08;
      7'd15: kbd_lower = 8'h09;
      7'd16: kbd_lower = 8'h71;
      7'd17: kbd_lower = 8'h77;
      7'd18: kbd_lower = 8'h65;
      7'd19: kbd_lower = 8'h72;
      7'd20: kbd_lower = 8'h74;
      7'd21: kbd_lower = 8'h79;
      7'd22: kbd_lower = 8'h75;
      7'd23: kbd_lower = 8'h69;
      7'd24: kbd_lower = 8'h6F;
      7'd25: kbd_lower = 8'h70;
      7'd26: kbd_lower = 8'h5B;
      7'd27: kbd_lower = 8'h5D;
      7'd28: kbd_lower = 8'h0A;
      7'd30: kbd_lower = 8'h61;
      7'd31: kbd_lower = 8'h73;
      7'd32: kbd_lower = 8'h64;
      7'd33: kbd_lower = 8'h66;
      7'd34: kbd_lower = 8'h67;
      7'd35: kbd_lower = 8'h68;
      7'd36: kbd_lower = 8'h6A;
      7'd37: kbd_lower = 8'h6B;
      7'd38: kbd_lower = 8'h6C;
      7'd39: kbd_lower = 8'h3B;
      7'd40: kbd_lower = 8'h27;
      7'd41: kbd_lower = 8'h60;
      7'd43: kbd_lower = 8'h5C;
      7'd44: kbd_lower = 8'h7A;
      7'd45: kbd_lower = 8'h78;
      7'd46: kbd_lower = 8'h63;
      7'd47: kbd_lower = 8'h76;
      7'd48: kbd_lower = 8'h62;
      7'd49: kbd_lower = 8'h6E;
      7'd50: kbd_lower = 8'h6D;
      7'd51: kbd_lower = 8'h2C;
      7'd52: kbd_lower = 8'h2E;
      7'd53: kbd_lower = 8'h2F;
      7'd55: kbd_lower = 8'h2A;
      7'd57: kbd_lower = 8'h20;
      7'd72: kbd_lower = 8'd38;
      7'd74: kbd_lower = 8'h2D;
      7'd75: kbd_lower = 8'd37;
      7'd77: kbd_lower = 8'd39;
      7'd78: kbd_lower = 8'h2B;
      7'd80: kbd_lower = 8'd40;
      default: kbd_lower = 8'h00;
    endcase
  endfunction

  // shifted table, codes past the end give zero
  function automatic logic [7:0] kbd_upper(input logic [6:0] idx);
    case (idx)
      7'd1:  kbd_upper = 8'h1B;
      7'd2:  kbd_upper = 8'h21;
      7'd3:  kbd_upper = 8'h40;
      7'd4:  kbd_upper = 8'h23;
      7'd5:  kbd_upper = 8'h24;
      7'd6:  kbd_upper = 8'h25;
      7'd7:  kbd_upper = 8'h5E;
      7'd8:  kbd_upper = 8'h26;
      7'd9:  kbd_upper = 8'h2A;
      7'd10: kbd_upper = 8'h28;
      7'd11: kbd_upper = 8'h29;
      7'd12: kbd_upper = 8'h5F;
      7'd13: kbd_upper = 8'h2B;
      7'd14: kbd_upper = 8'h08;
      7'd15: kbd_upper = 8'h09;
      7'd16: kbd_upper = 8'h51;
      7'd17: kbd_upper = 8'h57;
      7'd18: kbd_upper = 8'h45;
      7'd19: kbd_upper = 8'h52;
      7'd20: kbd_upper = 8'h54;
      7'd21: kbd_upper = 8'h59;
      7'd22: kbd_upper = 8'h55;
      7'd23: kbd_upper = 8'h49;
      7'd24: kbd_upper = 8'h4F;
      7'd25: kbd_upper = 8'h50;
      7'd26: kbd_upper = 8'h7B;
      7'd27: kbd_upper = 8'h7D;
      7'd28: kbd_upper = 8'h0A;
      7'd30: kbd_upper = 8'h41;
      7'd31: kbd_upper = 8'h53;
      7'd32: kbd_upper = 8'h44;
      7'd33: kbd_upper = 8'h46;
      7'd34: kbd_upper = 8'h47;
      7'd35: kbd_upper = 8'h48;
      7'd36: kbd_upper = 8'h4A;
      7'd37: kbd_upper = 8'h4B;
      7'd38: kbd_upper = 8'h4C;
      7'd39: kbd_upper = 8'h3A;
      7'd40: kbd_upper = 8'h22;
      7'd41: kbd_upper = 8'h7E;
      7'd43: kbd_upper = 8'h7C;
      7'd44: kbd_upper = 8'h5A;
      7'd45: kbd_upper = 8'h58;
      7'd46: kbd_upper = 8'h43;
      7'd47: kbd_upper = 8'h56;
      7'd48: kbd_upper = 8'h42;
      7'd49: kbd_upper = 8'h4E;
      7'd50: kbd_upper = 8'h4D;
      7'd51: kbd_upper = 8'h3C;
      7'd52: kbd_upper = 8'h3E;
      7'd53: kbd_upper = 8'h3F;
      7'd55: kbd_upper = 8'h2A;
      7'd57: kbd_upper = 8'h20;
      7'd74: kbd_upper = 8'h2D;
      7'd78: kbd_upper = 8'h2B;
      default: kbd_upper = 8'h00;
    endcase
  endfunction

endpackage

/* hdl/kbd_ram.sv */
// kbd_ram: generic single-clock RAM, one write port and one read port
// with registered read data (old data on a same-address write).
// Depends on nothing.
module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/scancode_to_ascii_keyboard_buffer.sv */
// scancode_to_ascii_keyboard_buffer: set-1 scancode decoder with a
// character ring, held-letter map and read/query/clear commands.
// Depends on kbd_pkg and kbd_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | input     | in_valid / in_stall   | cmd, scan_code, query_char
//   out     | output    | out_valid / out_stall | read_char, read_valid,
//           |           |                       | letter_held, snapshot,count
//
// One item per cycle sustained while out_stall is low; each item passes the
// input register and then the result register, which drives out_valid.
// The ring read address leads the registered RAM output: the next index when the
// held item moves on, else the current one, with a bypass for a same-cycle push.
// Reset is synchronous active low and clears control state, not ring or payload.
// A stalled result holds; the input register keeps taking items while it is empty.
module scancode_to_ascii_keyboard_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_scan_code,
  input  logic [7:0]          in_query_char,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_read_char,
  output logic                out_read_valid,
  output logic                out_letter_held,
  output logic                out_snapshot_requested,
  output logic [8:0]          out_buffered_count
);
  import kbd_pkg::*;

  // input register
  logic       s1_v_r;
  logic [1:0] s1_cmd_r;
  logic [7:0] s1_sc_r;
  logic [7:0] s1_q_r;

  // keyboard and ring state
  logic        shift_r, shift_nxt;
  logic        caps_r, caps_nxt;
  logic        snap_r, snap_nxt;
  logic [25:0] held_r, held_nxt;
  ring_idx_t   rd_idx_r, rd_idx_nxt;
  ring_idx_t   wr_idx_r, wr_idx_nxt;
  ring_cnt_t   count_r, count_nxt;

  // ring read bypass
  logic        byp_hit_r;
  logic [7:0]  byp_data_r;

  // result register
  logic        out_v_r;
  logic [7:0]  rc_r, rc_nxt;
  logic        rv_r, rv_nxt;
  logic        lh_r, lh_nxt;

  // datapath
  logic        out_ok;
  logic        adv;
  logic        push;
  logic [7:0]  push_char;
  logic [7:0]  raw_low;
  logic [7:0]  raw_up;
  logic        is_letter;
  logic [4:0]  letter_idx;
  logic        use_upper;
  logic [7:0]  qc;
  logic [7:0]  ring_q;
  logic [7:0]  ring_char;
  ring_idx_t   ring_raddr;

  // pipeline control
  assign out_ok   = !out_v_r || !out_stall;
  assign adv      = rst_n && s1_v_r && out_ok;
  assign in_stall = s1_v_r && !out_ok;

  // table lookups and letter detection
  assign raw_low    = kbd_lower(s1_sc_r[6:0]);
  assign raw_up     = kbd_upper(s1_sc_r[6:0]);
  assign is_letter  = (raw_low >= CH_LOW_A) && (raw_low <= CH_LOW_Z);
  assign letter_idx = 5'(raw_low - CH_LOW_A);
  assign use_upper  = is_letter ? (shift_r ^ caps_r) : shift_r;
  assign ring_char  = byp_hit_r ? byp_data_r : ring_q;

  // command execution
  always_comb begin
    shift_nxt  = shift_r;
    caps_nxt   = caps_r;
    snap_nxt   = snap_r;
    held_nxt   = held_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    count_nxt  = count_r;
    rc_nxt     = 8'h00;
    rv_nxt     = 1'b0;
    lh_nxt     = 1'b0;
    push       = 1'b0;
    push_char  = use_upper ? raw_up : raw_low;
    qc         = s1_q_r;
    if ((s1_q_r >= CH_UP_A) && (s1_q_r <= CH_UP_Z)) begin
      qc = s1_q_r + CH_CASE;
    end

    unique case (s1_cmd_r)
      CMD_SCAN: begin
        case (s1_sc_r) inside
          SC_LSHIFT, SC_RSHIFT:         shift_nxt = 1'b1;
          SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_nxt = 1'b0;
          SC_LCTRL:                     snap_nxt  = 1'b1;
          SC_CAPS:                      caps_nxt  = !caps_r;
          SC_NONE, SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT: begin
          end
          default: begin
            if (s1_sc_r[7]) begin
              // break code releases a letter
              if (is_letter) begin
                held_nxt[letter_idx] = 1'b0;
              end
            end else begin
              if (is_letter) begin
                held_nxt[letter_idx] = 1'b1;
              end
              push = 1'b1;
            end
          end
        endcase
        // push, dropping the oldest entry when full
        if (push) begin
          wr_idx_nxt = ring_bump(wr_idx_r);
          if (count_r == ring_cnt_t'(RING_DEPTH)) begin
            rd_idx_nxt = ring_bump(rd_idx_r);
          end else begin
            count_nxt = ring_cnt_t'(count_r + 1'b1);
          end
        end
      end
      CMD_READ: begin
        if (count_r == '0) begin
          rc_nxt = CH_EMPTY;
        end else begin
          rc_nxt     = ring_char;
          rv_nxt     = 1'b1;
          rd_idx_nxt = ring_bump(rd_idx_r);
          count_nxt  = ring_cnt_t'(count_r - 1'b1);
        end
      end
      CMD_QUERY: begin
        if ((qc >= CH_LOW_A) && (qc <= CH_LOW_Z)) begin
          lh_nxt = held_r[5'(qc - CH_LOW_A)];
        end
      end
      CMD_CLEAR: begin
        rd_idx_nxt = '0;
        wr_idx_nxt = '0;
        count_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // ring read address runs ahead of the registered read, held while the item waits
  assign ring_raddr = adv ? rd_idx_nxt : rd_idx_r;

  kbd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (adv && push),
    .waddr (wr_idx_r),
    .wdata (push_char),
    .raddr (ring_raddr),
    .rdata (ring_q)
  );

  // bypass when the character being read is written this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= adv && push && (wr_idx_r == ring_raddr);
    end
    byp_data_r <= push_char;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_v_r || adv) begin
      s1_v_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_cmd_r <= in_cmd;
      s1_sc_r  <= in_scan_code;
      s1_q_r   <= in_query_char;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      caps_r   <= 1'b0;
      snap_r   <= 1'b0;
      held_r   <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      count_r  <= '0;
    end else if (adv) begin
      shift_r  <= shift_nxt;
      caps_r   <= caps_nxt;
      snap_r   <= snap_nxt;
      held_r   <= held_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
    if (adv) begin
      rc_r                   <= rc_nxt;
      rv_r                   <= rv_nxt;
      lh_r                   <= lh_nxt;
      out_snapshot_requested <= snap_nxt;
      out_buffered_count     <= 9'(count_nxt);
    end
  end

  assign out_valid       = out_v_r;
  assign out_read_char   = rc_r;
  assign out_read_valid  = rv_r;
  assign out_letter_held = lh_r;

`ifndef NO_ASSERTIONS
  // fill count never passes the ring depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ring_cnt_t'(RING_DEPTH))
    else $error("ring fill count above depth");

  // an empty or full ring has its indices aligned
  a_idx_align: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == ring_cnt_t'(RING_DEPTH)) |-> (rd_idx_r == wr_idx_r))
    else $error("ring indices out of step with fill count");

  // snapshot flag is sticky until reset
  a_snap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    snap_r |=> snap_r)
    else $error("snapshot flag dropped");

  // a popped character never coexists with a held-letter report
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && rv_r) |-> !lh_r)
    else $error("read and query results mixed");
`endif

endmodule
